>>> design/phfc_pkg.sv
package phfc_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned SCAN_W     = 16;
    localparam int unsigned BLINK_W    = 16;
    localparam int unsigned DETECT_W   = 24;

    localparam logic [CFG_IDX_W-1:0] REG_PIN_LOW_OK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_DETECT  = 2'd3;

    localparam logic                  PIN_LOW_OK_RST     = 1'b1;
    localparam logic [SCAN_W-1:0]     SCAN_INTERVAL_RST  = 16'd100;
    localparam logic [BLINK_W-1:0]    BLINK_INTERVAL_RST = 16'd500;
    localparam logic [DETECT_W-1:0]   EMPTY_DETECT_RST   = 24'd300000;

    typedef struct packed {
        logic                pin_low_ok;
        logic [SCAN_W-1:0]   scan_interval_ticks;
        logic [BLINK_W-1:0]  blink_interval_ticks;
        logic [DETECT_W-1:0] empty_detect_ticks;
    } cfg_t;

    typedef struct packed {
        logic pump_drive;
        logic heater_drive;
        logic led_drive;
        logic supply_empty;
        logic level_ok;
    } result_t;

endpackage

>>> design/phfc_cfg.sv
module phfc_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [phfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [phfc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output phfc_pkg::cfg_t                      cfg
);

    phfc_pkg::cfg_t cfg_reg;
    phfc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                phfc_pkg::REG_PIN_LOW_OK:
                    cfg_next.pin_low_ok = cfg_data[0];
                phfc_pkg::REG_SCAN_INTERVAL:
                    cfg_next.scan_interval_ticks = cfg_data[phfc_pkg::SCAN_W-1:0];
                phfc_pkg::REG_BLINK_INTERVAL:
                    cfg_next.blink_interval_ticks = cfg_data[phfc_pkg::BLINK_W-1:0];
                phfc_pkg::REG_EMPTY_DETECT:
                    cfg_next.empty_detect_ticks = cfg_data[phfc_pkg::DETECT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pin_low_ok           <= phfc_pkg::PIN_LOW_OK_RST;
            cfg_reg.scan_interval_ticks  <= phfc_pkg::SCAN_INTERVAL_RST;
            cfg_reg.blink_interval_ticks <= phfc_pkg::BLINK_INTERVAL_RST;
            cfg_reg.empty_detect_ticks   <= phfc_pkg::EMPTY_DETECT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/phfc_core.sv
module phfc_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                level_pin,
    input  phfc_pkg::cfg_t      cfg,
    output phfc_pkg::result_t   result
);

    localparam logic [phfc_pkg::SCAN_W-1:0]   SCAN_MAX   = '1;
    localparam logic [phfc_pkg::BLINK_W-1:0]  BLINK_MAX  = '1;
    localparam logic [phfc_pkg::DETECT_W-1:0] DETECT_MAX = '1;

    logic                            pump_reg, pump_next;
    logic                            heater_reg, heater_next;
    logic                            fault_reg, fault_next;
    logic                            running_reg, running_next;
    logic [phfc_pkg::DETECT_W-1:0]   timeout_reg, timeout_next;
    logic [phfc_pkg::SCAN_W-1:0]     scan_reg, scan_next;
    logic [phfc_pkg::BLINK_W-1:0]    blink_reg, blink_next;
    logic                            led_reg, led_next;
    logic                            blink_en_reg, blink_en_next;
    logic                            level_ok_reg, level_ok_next;

    logic                            level_good;
    logic [phfc_pkg::SCAN_W-1:0]     scan_inc;
    logic [phfc_pkg::BLINK_W-1:0]    blink_inc;
    logic [phfc_pkg::DETECT_W-1:0]   timeout_inc;

    always_comb
    begin
        level_good = cfg.pin_low_ok ? !level_pin : level_pin;
        scan_inc = (scan_reg == SCAN_MAX) ? SCAN_MAX : scan_reg + 1'b1;
        blink_inc = (blink_reg == BLINK_MAX) ? BLINK_MAX : blink_reg + 1'b1;
        if (running_reg && (timeout_reg != DETECT_MAX))
        begin
            timeout_inc = timeout_reg + 1'b1;
        end
        else
        begin
            timeout_inc = timeout_reg;
        end

        pump_next     = pump_reg;
        heater_next   = heater_reg;
        fault_next    = fault_reg;
        running_next  = running_reg;
        timeout_next  = timeout_inc;
        scan_next     = scan_inc;
        blink_next    = blink_inc;
        led_next      = led_reg;
        blink_en_next = blink_en_reg;
        level_ok_next = level_ok_reg;

        if (scan_inc >= cfg.scan_interval_ticks)
        begin
            scan_next = '0;
            level_ok_next = level_good;
            if (pump_reg && !level_good)
            begin
                if (!running_reg)
                begin
                    running_next = 1'b1;
                    timeout_next = '0;
                end
            end
            else if (level_good)
            begin
                running_next = 1'b0;
                fault_next = 1'b0;
            end
            else
            begin
                running_next = 1'b0;
            end

            if (running_next && (timeout_next > cfg.empty_detect_ticks))
            begin
                fault_next = 1'b1;
                running_next = 1'b0;
            end

            if (fault_next)
            begin
                pump_next = 1'b0;
                heater_next = 1'b0;
                blink_en_next = 1'b1;
            end
            else if (level_good)
            begin
                pump_next = 1'b0;
                heater_next = 1'b1;
                blink_en_next = 1'b0;
            end
            else
            begin
                pump_next = 1'b1;
                heater_next = 1'b0;
                blink_en_next = 1'b0;
            end
        end

        if (blink_en_next)
        begin
            if (blink_inc >= cfg.blink_interval_ticks)
            begin
                blink_next = '0;
                led_next = !led_reg;
            end
        end
        else
        begin
            led_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pump_reg     <= 1'b0;
            heater_reg   <= 1'b0;
            fault_reg    <= 1'b0;
            running_reg  <= 1'b0;
            timeout_reg  <= '0;
            scan_reg     <= '0;
            blink_reg    <= '0;
            led_reg      <= 1'b0;
            blink_en_reg <= 1'b0;
            level_ok_reg <= 1'b0;
        end
        else if (step)
        begin
            pump_reg     <= pump_next;
            heater_reg   <= heater_next;
            fault_reg    <= fault_next;
            running_reg  <= running_next;
            timeout_reg  <= timeout_next;
            scan_reg     <= scan_next;
            blink_reg    <= blink_next;
            led_reg      <= led_next;
            blink_en_reg <= blink_en_next;
            level_ok_reg <= level_ok_next;
        end
    end

    assign result.pump_drive   = pump_next;
    assign result.heater_drive = heater_next;
    assign result.led_drive    = led_next;
    assign result.supply_empty = fault_next;
    assign result.level_ok     = level_ok_next;

endmodule

>>> design/pump_heater_fill_controller.sv
// Fill pump and heater controller with empty-supply detection.
// Each request on the input channel (in_valid, in_stall, level_pin) is one
// millisecond tick carrying the raw level-switch pin. Each tick produces
// exactly one request on the output channel (out_valid, out_stall) with the
// pump, heater and LED drives, the latched supply-empty fault and the level
// result of the most recent scan.
// A tick passes through an input register and then one combinational update
// of the controller state into the result register, which presents its
// result on the output channel. One tick is accepted every cycle while the
// receiver does not hold out_stall.
// When the receiver holds out_stall, the result register keeps its request,
// one more tick may wait in the input register, and then in_stall rises
// until the result is taken.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data, by the user only while no tick is in flight; it is not enforced.
// Reset clears all controller state and counters, loads the default
// configuration and leaves both channels empty.
module pump_heater_fill_controller
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [phfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [phfc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                level_pin,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                pump_drive,
    output logic                                heater_drive,
    output logic                                led_drive,
    output logic                                supply_empty,
    output logic                                level_ok
);

    phfc_pkg::cfg_t     cfg;
    phfc_pkg::result_t  result;
    phfc_pkg::result_t  result_reg;

    logic in_valid_reg, in_valid_next;
    logic pin_reg;
    logic out_valid_reg, out_valid_next;
    logic advance;
    logic accept;

    phfc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    phfc_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .level_pin (pin_reg),
        .cfg       (cfg),
        .result    (result)
    );

    always_comb
    begin
        advance = in_valid_reg && (!out_valid_reg || !out_stall);
        in_stall = in_valid_reg && !advance;
        accept = in_valid && !in_stall;

        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pin_reg <= level_pin;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pump_drive   = result_reg.pump_drive;
    assign heater_drive = result_reg.heater_drive;
    assign led_drive    = result_reg.led_drive;
    assign supply_empty = result_reg.supply_empty;
    assign level_ok     = result_reg.level_ok;

endmodule
